@@ hdl/mfa_pkg.sv @@
// ----------------------------------------------------------------------------
// mfa_pkg
// Shared types and codes of the mixed fraction arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfa_pkg;

   // Operation codes carried in req_type.
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_NEGATIVE = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // Flags returned by the shared adder.
   typedef struct packed {
      logic borrow;
      logic zero;
   } alu_flags_type;

endpackage

`default_nettype wire

@@ hdl/mfa_if.sv @@
// ----------------------------------------------------------------------------
// mfa_if
// Request and response channels of the mixed fraction arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfa_req_if #(
   parameter int W = 16
);
   logic         valid;
   logic         ready;
   logic [2:0]   req_type;
   logic [W-1:0] a_whole;
   logic [W-1:0] a_num;
   logic [W-1:0] a_den;
   logic [W-1:0] b_whole;
   logic [W-1:0] b_num;
   logic [W-1:0] b_den;

   modport source (output valid, req_type, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   input ready);
   modport sink (input valid, req_type, a_whole, a_num, a_den, b_whole, b_num, b_den,
                 output ready);
endinterface

interface mfa_rsp_if #(
   parameter int W = 16
);
   logic         valid;
   logic         ready;
   logic [W-1:0] r_whole;
   logic [W-1:0] r_num;
   logic [W-1:0] r_den;
   logic         is_less;
   logic         is_equal;
   logic [1:0]   status;

   modport source (output valid, r_whole, r_num, r_den, is_less, is_equal, status,
                   input ready);
   modport sink (input valid, r_whole, r_num, r_den, is_less, is_equal, status,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/mixed_fraction_arithmetic.sv @@
// ----------------------------------------------------------------------------
// mixed_fraction_arithmetic
// Add, subtract, multiply, divide or compare two mixed numbers and return a
// normalized mixed number with a reduced proper fraction.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on req_ch carries the operation code and two mixed
// numbers whole + num/den; a denominator of zero makes the operand the plain
// whole number. One response transaction on rsp_ch follows each request with
// the whole part, the reduced fraction (zero numerator shown with a zero
// denominator), the compare flags and a status code.
// The block works on one transaction at a time. Every multiplication runs
// shift-and-add through the single shared adder, one multiplier bit per cycle
// and stopping once the multiplier is spent; every division is restoring, one
// quotient bit per cycle over 4*W+2 bits (W = VALUE_WIDTH). Operand values and
// cross products come first (a multiply request then forms the product), then
// the whole-part division, and reducing a nonzero fraction runs the Euclid
// remainder steps. The next request can be taken in the cycle after the
// response is taken. Compare, divide-by-zero and negative-difference requests
// end right after the products.
// Synchronous reset returns the sequencer to idle and drops rsp_ch.valid.
// req_ch.ready is high only while idle; when the receiver stalls, the response
// holds on rsp_ch until it is taken and no new request is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_fraction_arithmetic #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   mfa_req_if.sink      req_ch,
   mfa_rsp_if.source    rsp_ch
);

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W + 1;       // operand value numerator
   localparam int NW = 4 * W + 2;       // widest intermediate numerator
   localparam int AW = NW + 1;          // adder and partial remainder
   localparam int CW = $clog2(NW);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP_A, S_PREP_B, S_PREP_L, S_MUL, S_OPSEL,
      S_DIV, S_DIVRET, S_GCD, S_RESP
   } state_type;

   // Where a multiply or divide returns to.
   typedef enum logic [3:0] {
      R_PA, R_PB, R_L, R_R, R_D, R_PROD, R_Q, R_MOD, R_NN, R_DD
   } ret_type;

   state_type           state_ff;
   ret_type             ret_ff;
   logic [2:0]          op_ff;
   logic [W-1:0]        aw_ff, an_ff, ad_ff, bw_ff, bn_ff, bd_ff;
   logic [PW-1:0]       pa_ff, pb_ff;
   logic [W-1:0]        qa_ff, qb_ff;
   logic [NW-1:0]       l_ff, r_ff, n_ff, d_ff;
   logic [NW-1:0]       acc_ff, mc_ff;
   logic [PW-1:0]       mp_ff;
   logic [AW-1:0]       rm_ff;
   logic [NW-1:0]       dv_ff, ds_ff;
   logic [CW-1:0]       cnt_ff;
   logic [W-1:0]        rw_ff, rn_ff, rd_ff;
   logic                less_ff, eq_ff;
   mfa_pkg::status_type st_ff;

   logic [AW-1:0]          alu_a, alu_b, alu_res;
   logic                   alu_sub;
   mfa_pkg::alu_flags_type alu_flags;
   logic [AW-1:0]          div_shift;

   // Partial remainder shifted left with the next dividend bit.
   assign div_shift = {rm_ff[AW-2:0], dv_ff[NW-1]};

   // Operand selection for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            alu_a = {1'b0, acc_ff};
            alu_b = {1'b0, mc_ff};
         end
         S_DIV: begin
            alu_a   = div_shift;
            alu_b   = {1'b0, ds_ff};
            alu_sub = 1'b1;
         end
         S_OPSEL: begin
            alu_a   = {1'b0, l_ff};
            alu_b   = {1'b0, r_ff};
            alu_sub = (op_ff != mfa_pkg::OP_ADD);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   mfa_alu #(.AW(AW)) u_mfa_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .flags  (alu_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff   <= req_ch.req_type;
                  aw_ff   <= req_ch.a_whole;
                  an_ff   <= req_ch.a_num;
                  ad_ff   <= req_ch.a_den;
                  bw_ff   <= req_ch.b_whole;
                  bn_ff   <= req_ch.b_num;
                  bd_ff   <= req_ch.b_den;
                  rw_ff   <= '0;
                  rn_ff   <= '0;
                  rd_ff   <= '0;
                  less_ff <= 1'b0;
                  eq_ff   <= 1'b0;
                  st_ff   <= mfa_pkg::ST_OK;
                  state_ff <= S_PREP_A;
               end
            end
            // Operand value: whole * den + num over den, or whole over one.
            S_PREP_A: begin
               if (ad_ff == '0) begin
                  pa_ff    <= {{(PW-W){1'b0}}, aw_ff};
                  qa_ff    <= W'(1);
                  state_ff <= S_PREP_B;
               end else begin
                  acc_ff   <= {{(NW-W){1'b0}}, an_ff};
                  mc_ff    <= {{(NW-W){1'b0}}, aw_ff};
                  mp_ff    <= {{(PW-W){1'b0}}, ad_ff};
                  ret_ff   <= R_PA;
                  state_ff <= S_MUL;
               end
            end
            S_PREP_B: begin
               if (bd_ff == '0) begin
                  pb_ff    <= {{(PW-W){1'b0}}, bw_ff};
                  qb_ff    <= W'(1);
                  state_ff <= S_PREP_L;
               end else begin
                  acc_ff   <= {{(NW-W){1'b0}}, bn_ff};
                  mc_ff    <= {{(NW-W){1'b0}}, bw_ff};
                  mp_ff    <= {{(PW-W){1'b0}}, bd_ff};
                  ret_ff   <= R_PB;
                  state_ff <= S_MUL;
               end
            end
            S_PREP_L: begin
               acc_ff   <= '0;
               mc_ff    <= {{(NW-PW){1'b0}}, pa_ff};
               mp_ff    <= {{(PW-W){1'b0}}, qb_ff};
               ret_ff   <= R_L;
               state_ff <= S_MUL;
            end
            // Shift-and-add multiply, ends early once the multiplier is spent.
            S_MUL: begin
               if (mp_ff == '0) begin
                  unique case (ret_ff)
                     R_PA: begin
                        pa_ff    <= acc_ff[PW-1:0];
                        qa_ff    <= ad_ff;
                        state_ff <= S_PREP_B;
                     end
                     R_PB: begin
                        pb_ff    <= acc_ff[PW-1:0];
                        qb_ff    <= bd_ff;
                        state_ff <= S_PREP_L;
                     end
                     R_L: begin
                        l_ff   <= acc_ff;
                        acc_ff <= '0;
                        mc_ff  <= {{(NW-PW){1'b0}}, pb_ff};
                        mp_ff  <= {{(PW-W){1'b0}}, qa_ff};
                        ret_ff <= R_R;
                     end
                     R_R: begin
                        r_ff   <= acc_ff;
                        acc_ff <= '0;
                        mc_ff  <= {{(NW-W){1'b0}}, qa_ff};
                        mp_ff  <= {{(PW-W){1'b0}}, qb_ff};
                        ret_ff <= R_D;
                     end
                     R_D: begin
                        d_ff     <= acc_ff;
                        state_ff <= S_OPSEL;
                     end
                     R_PROD: begin
                        n_ff     <= acc_ff;
                        dv_ff    <= acc_ff;
                        ds_ff    <= d_ff;
                        rm_ff    <= '0;
                        cnt_ff   <= '0;
                        ret_ff   <= R_Q;
                        state_ff <= S_DIV;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end else begin
                  if (mp_ff[0]) begin
                     acc_ff <= alu_res[NW-1:0];
                  end
                  mc_ff <= {mc_ff[NW-2:0], 1'b0};
                  mp_ff <= {1'b0, mp_ff[PW-1:1]};
               end
            end
            S_OPSEL: begin
               unique case (op_ff)
                  mfa_pkg::OP_ADD: begin
                     n_ff     <= alu_res[NW-1:0];
                     dv_ff    <= alu_res[NW-1:0];
                     ds_ff    <= d_ff;
                     rm_ff    <= '0;
                     cnt_ff   <= '0;
                     ret_ff   <= R_Q;
                     state_ff <= S_DIV;
                  end
                  mfa_pkg::OP_SUB: begin
                     if (alu_flags.borrow) begin
                        st_ff    <= mfa_pkg::ST_NEGATIVE;
                        state_ff <= S_RESP;
                     end else begin
                        n_ff     <= alu_res[NW-1:0];
                        dv_ff    <= alu_res[NW-1:0];
                        ds_ff    <= d_ff;
                        rm_ff    <= '0;
                        cnt_ff   <= '0;
                        ret_ff   <= R_Q;
                        state_ff <= S_DIV;
                     end
                  end
                  mfa_pkg::OP_MUL: begin
                     acc_ff   <= '0;
                     mc_ff    <= {{(NW-PW){1'b0}}, pa_ff};
                     mp_ff    <= pb_ff;
                     ret_ff   <= R_PROD;
                     state_ff <= S_MUL;
                  end
                  mfa_pkg::OP_DIV: begin
                     if (pb_ff == '0) begin
                        st_ff    <= mfa_pkg::ST_DIV_ZERO;
                        state_ff <= S_RESP;
                     end else begin
                        n_ff     <= l_ff;
                        d_ff     <= r_ff;
                        dv_ff    <= l_ff;
                        ds_ff    <= r_ff;
                        rm_ff    <= '0;
                        cnt_ff   <= '0;
                        ret_ff   <= R_Q;
                        state_ff <= S_DIV;
                     end
                  end
                  mfa_pkg::OP_CMP: begin
                     less_ff  <= alu_flags.borrow;
                     eq_ff    <= alu_flags.zero;
                     state_ff <= S_RESP;
                  end
                  default: begin
                     state_ff <= S_RESP;
                  end
               endcase
            end
            // Restoring division; quotient bits shift into the dividend.
            S_DIV: begin
               if (alu_flags.borrow) begin
                  rm_ff <= div_shift;
                  dv_ff <= {dv_ff[NW-2:0], 1'b0};
               end else begin
                  rm_ff <= alu_res;
                  dv_ff <= {dv_ff[NW-2:0], 1'b1};
               end
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(NW - 1)) begin
                  state_ff <= S_DIVRET;
               end
            end
            S_DIVRET: begin
               unique case (ret_ff)
                  R_Q: begin
                     if (dv_ff[NW-1:W] != '0) begin
                        st_ff    <= mfa_pkg::ST_OVERFLOW;
                        state_ff <= S_RESP;
                     end else begin
                        rw_ff <= dv_ff[W-1:0];
                        if (rm_ff == '0) begin
                           state_ff <= S_RESP;
                        end else begin
                           n_ff     <= rm_ff[NW-1:0];
                           l_ff     <= rm_ff[NW-1:0];
                           r_ff     <= d_ff;
                           state_ff <= S_GCD;
                        end
                     end
                  end
                  R_MOD: begin
                     l_ff     <= r_ff;
                     r_ff     <= rm_ff[NW-1:0];
                     state_ff <= S_GCD;
                  end
                  R_NN: begin
                     rn_ff    <= dv_ff[W-1:0];
                     dv_ff    <= d_ff;
                     ds_ff    <= l_ff;
                     rm_ff    <= '0;
                     cnt_ff   <= '0;
                     ret_ff   <= R_DD;
                     state_ff <= S_DIV;
                  end
                  R_DD: begin
                     if (dv_ff[NW-1:W] != '0) begin
                        st_ff <= mfa_pkg::ST_OVERFLOW;
                        rw_ff <= '0;
                        rn_ff <= '0;
                     end else begin
                        rd_ff <= dv_ff[W-1:0];
                     end
                     state_ff <= S_RESP;
                  end
                  default: begin
                     state_ff <= S_RESP;
                  end
               endcase
            end
            // Euclid: l holds a, r holds b; when b is zero, l is the divisor.
            S_GCD: begin
               rm_ff  <= '0;
               cnt_ff <= '0;
               if (r_ff == '0) begin
                  dv_ff  <= n_ff;
                  ds_ff  <= l_ff;
                  ret_ff <= R_NN;
               end else begin
                  dv_ff  <= l_ff;
                  ds_ff  <= r_ff;
                  ret_ff <= R_MOD;
               end
               state_ff <= S_DIV;
            end
            S_RESP: begin
               if (rsp_ch.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = (state_ff == S_RESP);
   assign rsp_ch.r_whole  = rw_ff;
   assign rsp_ch.r_num    = rn_ff;
   assign rsp_ch.r_den    = rd_ff;
   assign rsp_ch.is_less  = less_ff;
   assign rsp_ch.is_equal = eq_ff;
   assign rsp_ch.status   = st_ff;

endmodule

`default_nettype wire

@@ hdl/mfa_alu.sv @@
// ----------------------------------------------------------------------------
// mfa_alu
// Shared add/subtract unit with borrow and zero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mfa_alu #(
   parameter int AW = 67
) (
   input  wire logic [AW-1:0]         op_a,
   input  wire logic [AW-1:0]         op_b,
   input  wire logic                  sub,
   output logic [AW-1:0]              result,
   output mfa_pkg::alu_flags_type     flags
);

   logic [AW:0] sum;

   always_comb begin
      sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{AW{1'b0}}, sub};
   end

   assign result       = sum[AW-1:0];
   assign flags.borrow = sub & ~sum[AW];
   assign flags.zero   = (sum[AW-1:0] == '0);

endmodule

`default_nettype wire

@@ hdl/mfa_checker.sv @@
// ----------------------------------------------------------------------------
// mfa_checker
// Port-level assertions for the mixed fraction arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

module mfa_checker #(
   parameter int W = 16
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [W-1:0] r_whole,
   input wire logic [W-1:0] r_num,
   input wire logic [W-1:0] r_den,
   input wire logic         is_less,
   input wire logic         is_equal,
   input wire logic [1:0]   status
);

   // A pending response holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // One transaction at a time: no request taken while a response waits.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // After a request is taken the block is busy.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   // Error responses carry an all-zero payload.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != mfa_pkg::ST_OK) |->
         (r_whole == '0) && (r_num == '0) && (r_den == '0) && !is_less && !is_equal)
      else $error("error response with nonzero payload");

   // A zero numerator comes with a zero denominator.
   a_zero_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (r_num == '0) |-> (r_den == '0))
      else $error("zero numerator with nonzero denominator");

endmodule

bind mixed_fraction_arithmetic mfa_checker #(.W(VALUE_WIDTH)) u_mfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .r_whole   (rsp_ch.r_whole),
   .r_num     (rsp_ch.r_num),
   .r_den     (rsp_ch.r_den),
   .is_less   (rsp_ch.is_less),
   .is_equal  (rsp_ch.is_equal),
   .status    (rsp_ch.status)
);

`default_nettype wire
